// ===== rtl/core/mbpd_pkg.sv =====
package mbpd_pkg;

   localparam int BUTTONS_DEFAULT = 8;
   localparam int LEVEL_BITS      = 8;
   localparam int TIME_W          = 32;
   localparam int DEBOUNCE_W      = 16;
   localparam int COUNT_W         = 4;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 16;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd80;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_MS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_MASK  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BUTTON_COUNT = 2'd2;

   // one stored entry per button
   typedef struct packed {
      logic              seen_level;
      logic              reported;
      logic [TIME_W-1:0] change_time;
   } entry_type;

endpackage

// ===== rtl/core/multi_button_press_debouncer_unit.sv =====
// Channel  | Ports                         | Contents
// req      | req_tvalid/tready/tdata[39:0] | one poll: levels, now_ms
// rsp      | rsp_tvalid/tready/tdata[7:0]  | press_mask, one item per poll
// csr      | csr_wen/csr_index/csr_wdata   | debounce_ms, enable_mask, button_count
//
// An item runs from accept to result through these steps, with
// lim = min(button_count, BUTTONS, 8): one RAM read per button, the last
// entry's modify/write, a check that the loop is empty, and the result load.
// Synchronous active-high reset; the RAM needs no clearing pass (valid bits).
// Back in IDLE after the result load, a new poll is accepted even while the
// result waits; a second result waits in DONE until the output register frees up.
module multi_button_press_debouncer_unit #(
   parameter int BUTTONS = mbpd_pkg::BUTTONS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [39:0]                     req_tdata,  // [7:0] levels, [39:8] now_ms
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,  // [7:0] press_mask
   input  logic                            csr_wen,
   input  logic [mbpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mbpd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mbpd_pkg::*;

   // only buttons below the level width can ever be watched
   localparam int LIM_MAX = (BUTTONS < LEVEL_BITS) ? BUTTONS : LEVEL_BITS;
   localparam int ADDR_W  = (LIM_MAX > 1) ? $clog2(LIM_MAX) : 1;
   localparam int CNT_W   = $clog2(LIM_MAX + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // config registers
   logic [DEBOUNCE_W-1:0] debounce_ff, debounce_in;
   logic [LEVEL_BITS-1:0] enable_ff, enable_in;
   logic [COUNT_W-1:0]    count_ff, count_in;

   logic [1:0]            state_ff, state_in;
   logic                  primed_ff, primed_in;
   logic                  prime_item_ff, prime_item_in;
   logic [LEVEL_BITS-1:0] levels_ff, levels_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [CNT_W-1:0]      lim_ff, lim_in;
   logic [CNT_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic                  p1_valid_ff, p1_valid_in;
   logic [ADDR_W-1:0]     p1_idx_ff, p1_idx_in;
   logic [LEVEL_BITS-1:0] press_ff, press_in;
   logic                  out_valid_ff, out_valid_in;
   logic [LEVEL_BITS-1:0] out_press_ff, out_press_in;

   logic                  req_fire;
   logic                  rd_en;
   entry_type             rd_entry;
   entry_type             wr_entry;
   logic                  wr_en;
   logic                  lvl;
   logic [TIME_W-1:0]     ct;
   logic [TIME_W-1:0]     held;
   logic                  settled;
   logic                  press_bit;

   mbpd_state_ram #(
      .DEPTH  (LIM_MAX),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_cnt_ff[ADDR_W-1:0]),
      .rd_data (rd_entry),
      .wr_en   (wr_en),
      .wr_addr (p1_idx_ff),
      .wr_data (wr_entry)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_press_ff;

   // config writes
   always_comb begin
      debounce_in = debounce_ff;
      enable_in   = enable_ff;
      count_in    = count_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_DEBOUNCE_MS:  debounce_in = csr_wdata;
            CSR_ENABLE_MASK:  enable_in   = csr_wdata[LEVEL_BITS-1:0];
            CSR_BUTTON_COUNT: count_in    = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // per-button update of the entry read last cycle
   always_comb begin
      lvl       = levels_ff[p1_idx_ff];
      ct        = (lvl != rd_entry.seen_level) ? now_ff : rd_entry.change_time;
      held      = now_ff - ct;
      settled   = (held >= {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ff});
      press_bit = 1'b0;
      wr_entry.seen_level  = lvl;
      wr_entry.change_time = ct;
      wr_entry.reported    = rd_entry.reported;
      if (prime_item_ff) begin
         wr_entry.change_time = now_ff;
         wr_entry.reported    = !lvl;
      end else if (settled) begin
         if (!lvl) begin
            press_bit         = !rd_entry.reported;
            wr_entry.reported = 1'b1;
         end else begin
            wr_entry.reported = 1'b0;
         end
      end
      wr_en = p1_valid_ff && enable_ff[p1_idx_ff];
   end

   always_comb begin
      state_in      = state_ff;
      primed_in     = primed_ff;
      prime_item_in = prime_item_ff;
      levels_in     = levels_ff;
      now_in        = now_ff;
      lim_in        = lim_ff;
      rd_cnt_in     = rd_cnt_ff;
      p1_valid_in   = 1'b0;
      p1_idx_in     = rd_cnt_ff[ADDR_W-1:0];
      press_in      = press_ff;
      rd_en         = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_press_in  = out_press_ff;

      if (wr_en && press_bit) begin
         press_in[p1_idx_ff] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               levels_in     = req_tdata[LEVEL_BITS-1:0];
               now_in        = req_tdata[LEVEL_BITS +: TIME_W];
               prime_item_in = !primed_ff;
               primed_in     = 1'b1;
               rd_cnt_in     = '0;
               press_in      = '0;
               if (count_ff > COUNT_W'(LIM_MAX)) begin
                  lim_in = CNT_W'(LIM_MAX);
               end else begin
                  lim_in = count_ff[CNT_W-1:0];
               end
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (rd_cnt_ff < lim_ff) begin
               rd_en       = 1'b1;
               p1_valid_in = 1'b1;
               rd_cnt_in   = rd_cnt_ff + 1'b1;
            end else if (!p1_valid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_press_in = press_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= DEBOUNCE_RESET;
         enable_ff    <= '0;
         count_ff     <= '0;
         state_ff     <= ST_IDLE;
         primed_ff    <= 1'b0;
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         debounce_ff  <= debounce_in;
         enable_ff    <= enable_in;
         count_ff     <= count_in;
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         p1_valid_ff  <= p1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prime_item_ff <= prime_item_in;
      levels_ff     <= levels_in;
      now_ff        <= now_in;
      lim_ff        <= lim_in;
      rd_cnt_ff     <= rd_cnt_in;
      p1_idx_ff     <= p1_idx_in;
      press_ff      <= press_in;
      out_press_ff  <= out_press_in;
   end

endmodule

// ===== rtl/core/mbpd_state_ram.sv =====
module mbpd_state_ram #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output mbpd_pkg::entry_type rd_data,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  mbpd_pkg::entry_type wr_data
);
   import mbpd_pkg::*;

   entry_type        mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   entry_type        rd_data_ff;
   logic             rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // entries never written read as the reset value
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== bench/multi_button_press_debouncer_unit_checker.sv =====
`timescale 1ns / 100ps
module multi_button_press_debouncer_unit_checker #(
   parameter int BUTTONS = mbpd_pkg::BUTTONS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [39:0]                     req_tdata,   // [7:0] levels, [39:8] now_ms
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [7:0]                      rsp_tdata,   // [7:0] press_mask
   input  logic                            csr_wen,
   input  logic [mbpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mbpd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              pending_count,
   output int                              results_checked,
   output int                              presses_seen
);
   import mbpd_pkg::*;

   localparam int MAX_PRINTED = 40;

   // register copies
   logic [DEBOUNCE_W-1:0] debounce_ms;
   logic [LEVEL_BITS-1:0] enable_mask;
   logic [COUNT_W-1:0]    button_count;

   // per-button debounce state
   logic [BUTTONS-1:0] seen_level;
   logic [BUTTONS-1:0] reported;
   logic [TIME_W-1:0]  change_time [BUTTONS];
   logic               primed;

   logic [7:0] expected_press_q [$];

   task automatic report_mismatch(input string what);
      if (fail_count < MAX_PRINTED) $display("ERROR @%0t: %s", $time, what);
      fail_count++;
   endtask

   // one poll through the debounce state, returns the new-press mask
   task automatic debounce_poll(input logic [7:0] levels, input logic [TIME_W-1:0] now,
                                output logic [7:0] press);
      int                lim;
      logic [TIME_W-1:0] held;
      lim = button_count;
      if (lim > BUTTONS) lim = BUTTONS;
      if (lim > LEVEL_BITS) lim = LEVEL_BITS;
      press = '0;
      for (int i = 0; i < lim; i++) begin
         if (!enable_mask[i]) continue;
         if (!primed) begin
            seen_level[i]  = levels[i];
            change_time[i] = now;
            reported[i]    = !levels[i];
            continue;
         end
         if (levels[i] != seen_level[i]) begin
            seen_level[i]  = levels[i];
            change_time[i] = now;
         end
         held = now - change_time[i];
         if (held < {16'd0, debounce_ms}) continue;
         if (!levels[i]) begin
            if (!reported[i]) begin
               reported[i] = 1'b1;
               press[i]    = 1'b1;
            end
         end else begin
            reported[i] = 1'b0;
         end
      end
      primed = 1'b1;
   endtask

   always @(posedge clock) begin
      logic [7:0] press;
      logic [7:0] want;
      if (reset) begin
         debounce_ms  = DEBOUNCE_RESET;
         enable_mask  = '0;
         button_count = '0;
         seen_level   = '0;
         reported     = '0;
         primed       = 1'b0;
         for (int i = 0; i < BUTTONS; i++) change_time[i] = '0;
         expected_press_q.delete();
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_DEBOUNCE_MS:  debounce_ms  = csr_wdata[DEBOUNCE_W-1:0];
               CSR_ENABLE_MASK:  enable_mask  = csr_wdata[LEVEL_BITS-1:0];
               CSR_BUTTON_COUNT: button_count = csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            debounce_poll(req_tdata[7:0], req_tdata[39:8], press);
            expected_press_q.push_back(press);
            presses_seen += $countones(press);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_press_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result, press_mask %02h", rsp_tdata));
            end else begin
               want = expected_press_q.pop_front();
               results_checked++;
               if (rsp_tdata !== want)
                  report_mismatch($sformatf("press_mask %02h, expected %02h",
                                            rsp_tdata, want));
            end
         end
      end
      pending_count = expected_press_q.size();
   end

endmodule

// ===== bench/multi_button_press_debouncer_unit_tb.sv =====
`timescale 1ns / 100ps
module multi_button_press_debouncer_unit_tb;
   import mbpd_pkg::*;

   // index 3 is decoded by nothing; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int RANDOM_PHASES   = 8;
   localparam int POLLS_PER_PHASE = 63;
   // longest accept-to-result is with 8 buttons; leave margin
   localparam int IDLE_TAIL       = 16;
   // worst case ~530 items plus gaps, stalls and drains stays well
   // under the 5 ms timeout
   localparam int TIMEOUT_NS      = 5_000_000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [39:0]           req_tdata;   // [7:0] levels, [39:8] now_ms
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;   // [7:0] press_mask
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int fail_count;
   int pending_count;
   int results_checked;
   int presses_seen;

   // sender burst/gap knobs and receiver stall knobs, retuned per phase
   int burst_left;
   int burst_max;
   int max_gap;
   int stall_max;
   int stall_pct;
   int stall_left;

   // stimulus-side view of the buttons: intended level and bounce left
   logic [7:0]  key_intent;
   int          bounce_left [8];
   logic [31:0] now_ms;
   int          cur_debounce;
   int          items_sent;
   int          settings_used;

   multi_button_press_debouncer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   multi_button_press_debouncer_unit_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .results_checked (results_checked),
      .presses_seen    (presses_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

   // receiver: runs of ready broken by random stalls; stall_max 0 = always ready
   initial begin
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (stall_max > 0 && $urandom_range(0, 99) < stall_pct)
               stall_left = $urandom_range(1, stall_max);
         end
      end
   end

   // one register write, held for a single rising edge
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen   <= 1'b0;
      if (idx == CSR_DEBOUNCE_MS) cur_debounce = val;
   endtask

   // present one poll and hold it until accepted; valid stays up inside a burst
   task automatic send_poll(input logic [7:0] levels, input logic [31:0] now);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {now, levels};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (burst_left > 0 || max_gap == 0) begin
         if (burst_left > 0) burst_left--;
      end else begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, max_gap)) @(negedge clock);
         burst_left = $urandom_range(0, burst_max);
      end
   endtask

   // sender holds off until every pending result is back, then lets the
   // block settle; registers are only touched after this
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (IDLE_TAIL) @(negedge clock);
   endtask

   // well-formed key activity: each key flips now and then, bounces for a
   // few polls after a flip; a small share of polls is pure noise
   task automatic button_activity(input int polls);
      logic [7:0] levels;
      for (int k = 0; k < polls; k++) begin
         if ($urandom_range(0, 99) < 8) begin
            levels = 8'($urandom);
            if ($urandom_range(0, 2) == 0) now_ms = $urandom;
         end else begin
            for (int b = 0; b < 8; b++) begin
               if (bounce_left[b] == 0 && $urandom_range(0, 99) < 12) begin
                  key_intent[b]  = ~key_intent[b];
                  bounce_left[b] = $urandom_range(0, 3);
               end
               if (bounce_left[b] > 0) begin
                  levels[b] = 1'($urandom_range(0, 1));
                  bounce_left[b]--;
               end else begin
                  levels[b] = key_intent[b];
               end
            end
            // time step scaled to the window so presses actually mature
            if ($urandom_range(0, 49) == 0) now_ms += $urandom;
            else now_ms += $urandom_range(0, cur_debounce / 3 + 10);
         end
         send_poll(levels, now_ms);
      end
   endtask

   initial begin
      logic [31:0] t0;
      logic [7:0]  en;
      logic [3:0]  cnt;
      int          dbc;

      // every input known from time zero
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_wen       = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      burst_left    = 0;
      burst_max     = 6;
      max_gap       = 3;
      stall_max     = 4;
      stall_pct     = 30;
      stall_left    = 0;
      key_intent    = 8'hFF;
      cur_debounce  = DEBOUNCE_RESET;
      items_sent    = 0;
      settings_used = 0;
      for (int b = 0; b < 8; b++) bounce_left[b] = 0;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // button 7 left unwatched at priming; upper csr bits must be dropped
      write_reg(CSR_DEBOUNCE_MS, 16'd40);
      write_reg(CSR_ENABLE_MASK, 16'hFF7F);
      write_reg(CSR_BUTTON_COUNT, 16'h0008);
      write_reg(CSR_UNUSED, 16'hFFFF);
      settings_used++;

      // start just below the 32-bit wrap so held times span it; the press matures after it
      t0 = 32'hFFFF_FFC0;
      send_poll(8'h7C, t0);          // priming: keys 0,1 held -> this hold is never pressed
      send_poll(8'h7C, t0 + 20);
      send_poll(8'h7C, t0 + 60);
      send_poll(8'h78, t0 + 70);     // key 2 goes down, then bounces
      send_poll(8'h7C, t0 + 75);
      send_poll(8'h78, t0 + 80);
      send_poll(8'h78, t0 + 119);    // one ms short of the window
      send_poll(8'h78, t0 + 120);    // exactly the window, after the wrap
      send_poll(8'hFF, t0 + 130);    // release all, marks clear later
      send_poll(8'hFF, t0 + 200);
      send_poll(8'h00, t0 + 210);    // everything down
      send_poll(8'h00, t0 + 260);
      send_poll(8'hFF, 32'hFFFF_FFFF);
      send_poll(8'hFF, 32'h0000_0000);
      drain();

      // zero window: level counts in the poll that changes it
      write_reg(CSR_DEBOUNCE_MS, 16'd0);
      settings_used++;
      send_poll(8'h00, 32'd5);
      send_poll(8'hFF, 32'd5);
      send_poll(8'h00, 32'd5);
      drain();

      // key 7 newly watched, starts from its untouched reset entry
      write_reg(CSR_ENABLE_MASK, 16'h00FF);
      settings_used++;
      send_poll(8'h7F, 32'd6);
      drain();

      // count above 8 saturates; widest window
      write_reg(CSR_BUTTON_COUNT, 16'hFFFF);
      write_reg(CSR_DEBOUNCE_MS, 16'hFFFF);
      settings_used++;
      send_poll(8'hFF, 32'd100);
      send_poll(8'h00, 32'd200);
      send_poll(8'h00, 32'd200 + 32'd65534);
      send_poll(8'h00, 32'd200 + 32'd65535);
      drain();

      // partial count with sparse mask, then nothing watched at all
      write_reg(CSR_BUTTON_COUNT, 16'd3);
      write_reg(CSR_ENABLE_MASK, 16'h00AA);
      write_reg(CSR_DEBOUNCE_MS, 16'd10);
      settings_used++;
      send_poll(8'hFF, 32'h8000_0000);
      send_poll(8'h00, 32'h8000_000A);
      drain();
      write_reg(CSR_UNUSED, 16'h0000);
      write_reg(CSR_BUTTON_COUNT, 16'd0);
      settings_used++;
      send_poll(8'h00, 32'h8000_1000);
      drain();

      // ---- random part ----
      // first phases pin the extremes, the rest draw freely
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       dbc = 0;
            1:       dbc = 65535;
            default: dbc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(1, 200);
         endcase
         en  = (p == 2) ? 8'hFF : (p == 5) ? 8'h00 : 8'($urandom);
         cnt = (p == 3) ? 4'd15 : ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd8;
         write_reg(CSR_DEBOUNCE_MS, CSR_DATA_W'(dbc));
         write_reg(CSR_ENABLE_MASK, {8'($urandom_range(0, 255)), en});
         write_reg(CSR_BUTTON_COUNT, {12'($urandom_range(0, 4095)), cnt});
         if ($urandom_range(0, 1)) write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
         settings_used++;

         // some phases run flat out on both sides
         if (p % 3 == 0) begin
            max_gap   = 0;
            stall_max = 0;
         end else begin
            max_gap   = $urandom_range(1, 14);
            burst_max = $urandom_range(0, 20);
            stall_max = $urandom_range(1, 20);
            stall_pct = $urandom_range(10, 60);
         end
         burst_left = 0;
         now_ms     = $urandom;
         button_activity(POLLS_PER_PHASE);
         drain();
      end

      $display("Ran %0d polls under %0d register settings; %0d results compared.",
               items_sent, settings_used, results_checked);
      $display("Predicted %0d debounced presses, incl. zero/max windows and wrapped times.",
               presses_seen);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/mbpd_pkg.sv
rtl/core/mbpd_state_ram.sv
rtl/core/multi_button_press_debouncer_unit.sv
bench/multi_button_press_debouncer_unit_checker.sv
bench/multi_button_press_debouncer_unit_tb.sv
